>>> rtl/tt_pkg.sv
// ============================================================================
// tt_pkg: shared constants of the tanh series core
// Fixed-point formats, register map, the reciprocal table for the term
// denominators and the widths used by the arithmetic units.
// ============================================================================
package tt_pkg;

	// Argument and result widths
	localparam int X_W      = 32;
	localparam int RES_W    = 32;

	// Internal magnitudes are Q20.43 held in 63 bits
	localparam int FRAC_BITS = 43;
	localparam int MAG_W     = 63;
	localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};
	localparam logic [MAG_W-1:0] ONE_MAG = MAG_W'(1) << FRAC_BITS;

	// x squared in Q20.43 needs 50 bits for any 32-bit argument
	localparam int X2_W = 50;

	// Shared multiplier: 64 x 64 operands, 128-bit product
	localparam int OP_W   = 64;
	localparam int PROD_W = 128;

	// Final quotient: one integer bit and 30 fraction bits
	localparam int QUO_W = 31;

	// Denominator index n, the denominator being n*(n+1), n up to 62
	localparam int NIDX_W  = 6;
	localparam int DENOM_W = 12;

	// Configuration register map
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int TCNT_W  = 5;
	localparam logic [PADDR_W-3:0] REG_TERM_COUNT = 1'b0;
	localparam logic [TCNT_W-1:0]  TERM_COUNT_RST = 5'd8;

	// Reciprocals floor(2^63 / (n*(n+1))), indexed by n; unused ends are zero
	localparam logic [OP_W-1:0] TWO63 = 64'h8000_0000_0000_0000;
	localparam logic [OP_W-1:0] RECIP_TAB [64] = '{
		64'd0,
		TWO63 / (64'd1 * 64'd2),   TWO63 / (64'd2 * 64'd3),   TWO63 / (64'd3 * 64'd4),
		TWO63 / (64'd4 * 64'd5),   TWO63 / (64'd5 * 64'd6),   TWO63 / (64'd6 * 64'd7),
		TWO63 / (64'd7 * 64'd8),   TWO63 / (64'd8 * 64'd9),   TWO63 / (64'd9 * 64'd10),
		TWO63 / (64'd10 * 64'd11), TWO63 / (64'd11 * 64'd12), TWO63 / (64'd12 * 64'd13),
		TWO63 / (64'd13 * 64'd14), TWO63 / (64'd14 * 64'd15), TWO63 / (64'd15 * 64'd16),
		TWO63 / (64'd16 * 64'd17), TWO63 / (64'd17 * 64'd18), TWO63 / (64'd18 * 64'd19),
		TWO63 / (64'd19 * 64'd20), TWO63 / (64'd20 * 64'd21), TWO63 / (64'd21 * 64'd22),
		TWO63 / (64'd22 * 64'd23), TWO63 / (64'd23 * 64'd24), TWO63 / (64'd24 * 64'd25),
		TWO63 / (64'd25 * 64'd26), TWO63 / (64'd26 * 64'd27), TWO63 / (64'd27 * 64'd28),
		TWO63 / (64'd28 * 64'd29), TWO63 / (64'd29 * 64'd30), TWO63 / (64'd30 * 64'd31),
		TWO63 / (64'd31 * 64'd32), TWO63 / (64'd32 * 64'd33), TWO63 / (64'd33 * 64'd34),
		TWO63 / (64'd34 * 64'd35), TWO63 / (64'd35 * 64'd36), TWO63 / (64'd36 * 64'd37),
		TWO63 / (64'd37 * 64'd38), TWO63 / (64'd38 * 64'd39), TWO63 / (64'd39 * 64'd40),
		TWO63 / (64'd40 * 64'd41), TWO63 / (64'd41 * 64'd42), TWO63 / (64'd42 * 64'd43),
		TWO63 / (64'd43 * 64'd44), TWO63 / (64'd44 * 64'd45), TWO63 / (64'd45 * 64'd46),
		TWO63 / (64'd46 * 64'd47), TWO63 / (64'd47 * 64'd48), TWO63 / (64'd48 * 64'd49),
		TWO63 / (64'd49 * 64'd50), TWO63 / (64'd50 * 64'd51), TWO63 / (64'd51 * 64'd52),
		TWO63 / (64'd52 * 64'd53), TWO63 / (64'd53 * 64'd54), TWO63 / (64'd54 * 64'd55),
		TWO63 / (64'd55 * 64'd56), TWO63 / (64'd56 * 64'd57), TWO63 / (64'd57 * 64'd58),
		TWO63 / (64'd58 * 64'd59), TWO63 / (64'd59 * 64'd60), TWO63 / (64'd60 * 64'd61),
		TWO63 / (64'd61 * 64'd62), TWO63 / (64'd62 * 64'd63),
		64'd0
	};

	// Term denominator n*(n+1) on narrow operands
	function automatic logic [DENOM_W-1:0] denom(input logic [NIDX_W-1:0] n);
		logic [DENOM_W-1:0] a;
		logic [DENOM_W-1:0] b;
		a = DENOM_W'(n);
		b = DENOM_W'(n) + DENOM_W'(1);
		return DENOM_W'(a * b);
	endfunction

endpackage

>>> rtl/tanh_taylor_series_core.sv
// ============================================================================
// tanh_taylor_series_core: tanh(x) from truncated sinh and cosh series
// Sequencer, term datapath and configuration register around a shared
// multiplier and a serial divider.
// ============================================================================
// Usage notes.
// A transaction is offered on start with arg_x (Q3.28) and is taken at a
// clock edge where start is high and busy is low. busy then stays high until
// the result is issued. The result appears on tanh_value (Q1.30) and
// saturated for exactly one cycle, marked by done; the receiver cannot stall
// it, and busy is already low in that cycle so a new start may coincide.
// Squaring x is one pass through the shared 64 x 64 multiplier; each sinh or
// cosh term then costs three such passes (multiply by x squared, multiply by
// the reciprocal, multiply back for the correction) plus an accumulate state,
// and the closing ratio is formed in the divider, which finishes early when a
// ratio of two or more saturates. The number of terms per series is the
// effective term count, term_count limited to 1..MAX_TERMS. One transaction
// is in flight at a time, so a new one is taken only once busy is low.
// term_count is written through the APB port at byte address 0; the user must
// write it only while busy is low, which the block itself does not enforce.
// Reset clears the sequencer and sets term_count to 8.
// ============================================================================
module tanh_taylor_series_core #(
	parameter int MAX_TERMS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Command channel
	input  logic                        start,
	output logic                        busy,
	input  logic signed [tt_pkg::X_W-1:0]   arg_x,
	// Result channel
	output logic                        done,
	output logic signed [tt_pkg::RES_W-1:0] tanh_value,
	output logic                        saturated,
	// Configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tt_pkg::PADDR_W-1:0]  paddr,
	input  logic [tt_pkg::PDATA_W-1:0]  pwdata,
	output logic [tt_pkg::PDATA_W-1:0]  prdata,
	output logic                        pready
);
	import tt_pkg::*;

	localparam int CNT_W = $clog2(MAX_TERMS + 1);

	// Sequencer state codes
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_X2   = 3'd1;
	localparam logic [2:0] S_TMUL = 3'd2;
	localparam logic [2:0] S_RMUL = 3'd3;
	localparam logic [2:0] S_CMUL = 3'd4;
	localparam logic [2:0] S_ACC  = 3'd5;
	localparam logic [2:0] S_FDIV = 3'd6;

	logic [2:0]         state_q;
	logic               go_q;
	logic [TCNT_W-1:0]  term_count_q;
	logic               neg_q;
	logic [X_W-1:0]     xmag_q;
	logic [X2_W-1:0]    x2_q;
	logic [MAG_W-1:0]   ts_q;
	logic [MAG_W-1:0]   tc_q;
	logic [MAG_W-1:0]   ss_q;
	logic [MAG_W-1:0]   sc_q;
	logic [MAG_W-1:0]   t_q;
	logic [MAG_W-1:0]   qe_q;
	logic               corr_q;
	logic               flag_q;
	logic [CNT_W-1:0]   n_q;
	logic [CNT_W-1:0]   i_q;
	logic               sel_q;
	logic               done_q;
	logic [RES_W-1:0]   res_q;
	logic               sat_q;

	logic               accept;
	logic               cfg_wr;
	logic [X_W-1:0]     xmag_d;
	logic [5:0]         tcnt_ext;
	logic [5:0]         n_wide;
	logic [NIDX_W-1:0]  nidx;
	logic [DENOM_W-1:0] den_n;
	logic               mac_start;
	logic [OP_W-1:0]    mac_a;
	logic [OP_W-1:0]    mac_b;
	logic               mac_done;
	logic [PROD_W-1:0]  mac_prod;
	logic               div_start;
	logic               div_done;
	logic               div_ovf;
	logic [QUO_W-1:0]   div_quot;
	logic               term_sat;
	logic [MAG_W-1:0]   rem_c;
	logic [MAG_W-1:0]   cur_sum;
	logic [MAG_W:0]     sum_wide;
	logic [MAG_W-1:0]   new_term;
	logic [RES_W-1:0]   q_ext;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);
	assign cfg_wr = psel && penable && pwrite && pready;

	// Two's complement magnitude; the most negative argument maps to 2^31.
	assign xmag_d = arg_x[X_W-1] ? (~arg_x) + X_W'(1) : arg_x;

	// Effective term count, clamped to 1..MAX_TERMS.
	assign tcnt_ext = {1'b0, term_count_q};
	always_comb begin
		if (tcnt_ext == 6'd0) begin
			n_wide = 6'd1;
		end else if (tcnt_ext > 6'(MAX_TERMS)) begin
			n_wide = 6'(MAX_TERMS);
		end else begin
			n_wide = tcnt_ext;
		end
	end

	// Denominator index: 2i for sinh, 2i-1 for cosh.
	assign nidx  = NIDX_W'({i_q, 1'b0}) - NIDX_W'(sel_q);
	assign den_n = denom(nidx);

	// Operand selection for the shared multiplier.
	always_comb begin
		case (state_q)
			S_X2: begin
				mac_a = OP_W'(xmag_q);
				mac_b = OP_W'(xmag_q);
			end
			S_TMUL: begin
				mac_a = OP_W'(sel_q ? tc_q : ts_q);
				mac_b = OP_W'(x2_q);
			end
			S_RMUL: begin
				mac_a = OP_W'(t_q);
				mac_b = RECIP_TAB[nidx];
			end
			S_CMUL: begin
				mac_a = OP_W'(qe_q);
				mac_b = OP_W'(den_n);
			end
			default: begin
				mac_a = '0;
				mac_b = '0;
			end
		endcase
	end

	assign mac_start = go_q && ((state_q == S_X2) || (state_q == S_TMUL) ||
		(state_q == S_RMUL) || (state_q == S_CMUL));
	assign div_start = go_q && (state_q == S_FDIV);

	// Term product overflow: anything at or above 2^106 saturates.
	assign term_sat = (mac_prod[PROD_W-1:106] != '0);

	// Remainder of the reciprocal estimate; it is below twice the denominator.
	assign rem_c = t_q - mac_prod[MAG_W-1:0];

	// Corrected term and saturating sum, carry-in carries the correction.
	assign cur_sum  = sel_q ? sc_q : ss_q;
	assign new_term = qe_q + MAG_W'(corr_q);
	assign sum_wide = {1'b0, cur_sum} + {1'b0, qe_q} + (MAG_W + 1)'(corr_q);

	assign q_ext = RES_W'(div_quot);

	tt_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mac_start),
		.op_a   (mac_a),
		.op_b   (mac_b),
		.done   (mac_done),
		.prod   (mac_prod)
	);

	tt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (ss_q),
		.den    (sc_q),
		.done   (div_done),
		.ovf    (div_ovf),
		.quot   (div_quot)
	);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_count_q <= TERM_COUNT_RST;
		end else if (cfg_wr && (paddr[PADDR_W-1:2] == REG_TERM_COUNT)) begin
			term_count_q <= pwdata[TCNT_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[PADDR_W-1:2] == REG_TERM_COUNT) ?
		PDATA_W'(term_count_q) : '0;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			go_q    <= 1'b0;
			done_q  <= 1'b0;
			i_q     <= '0;
			n_q     <= '0;
			sel_q   <= 1'b0;
		end else begin
			go_q   <= 1'b0;
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						n_q     <= CNT_W'(n_wide);
						state_q <= S_X2;
						go_q    <= 1'b1;
					end
				end
				S_X2: begin
					if (mac_done) begin
						i_q   <= CNT_W'(1);
						sel_q <= 1'b0;
						go_q  <= 1'b1;
						if (n_q == CNT_W'(1)) begin
							state_q <= S_FDIV;
						end else begin
							state_q <= S_TMUL;
						end
					end
				end
				S_TMUL: begin
					if (mac_done) begin
						state_q <= S_RMUL;
						go_q    <= 1'b1;
					end
				end
				S_RMUL: begin
					if (mac_done) begin
						state_q <= S_CMUL;
						go_q    <= 1'b1;
					end
				end
				S_CMUL: begin
					if (mac_done) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					go_q <= 1'b1;
					if (!sel_q) begin
						sel_q   <= 1'b1;
						state_q <= S_TMUL;
					end else begin
						sel_q <= 1'b0;
						if (i_q == n_q - CNT_W'(1)) begin
							state_q <= S_FDIV;
						end else begin
							i_q     <= i_q + CNT_W'(1);
							state_q <= S_TMUL;
						end
					end
				end
				S_FDIV: begin
					if (div_done) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Term and sum datapath.
	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q  <= arg_x[X_W-1];
			xmag_q <= xmag_d;
			flag_q <= 1'b0;
		end
		if ((state_q == S_X2) && mac_done) begin
			x2_q <= mac_prod[X2_W+12:13];
			ts_q <= {16'b0, xmag_q, 15'b0};
			ss_q <= {16'b0, xmag_q, 15'b0};
			tc_q <= ONE_MAG;
			sc_q <= ONE_MAG;
		end
		if ((state_q == S_TMUL) && mac_done) begin
			if (term_sat) begin
				t_q    <= MAG_MAX;
				flag_q <= 1'b1;
			end else begin
				t_q <= mac_prod[105:FRAC_BITS];
			end
		end
		if ((state_q == S_RMUL) && mac_done) begin
			qe_q <= mac_prod[125:63];
		end
		if ((state_q == S_CMUL) && mac_done) begin
			corr_q <= (rem_c >= MAG_W'(den_n));
		end
		if (state_q == S_ACC) begin
			if (sel_q) begin
				tc_q <= new_term;
				sc_q <= sum_wide[MAG_W] ? MAG_MAX : sum_wide[MAG_W-1:0];
			end else begin
				ts_q <= new_term;
				ss_q <= sum_wide[MAG_W] ? MAG_MAX : sum_wide[MAG_W-1:0];
			end
			if (sum_wide[MAG_W]) begin
				flag_q <= 1'b1;
			end
		end
	end

	// Result register: sign applied to the quotient, overflow saturates.
	always_ff @(posedge clk) begin
		if ((state_q == S_FDIV) && div_done) begin
			if (div_ovf) begin
				res_q <= neg_q ? {1'b1, {(RES_W-1){1'b0}}} : {1'b0, {(RES_W-1){1'b1}}};
				sat_q <= 1'b1;
			end else begin
				res_q <= neg_q ? (~q_ext) + RES_W'(1) : q_ext;
				sat_q <= flag_q;
			end
		end
	end

	assign done       = done_q;
	assign tanh_value = res_q;
	assign saturated  = sat_q;

endmodule

>>> rtl/tt_mac.sv
// ============================================================================
// tt_mac: shared multi-cycle 64 x 64 multiplier
// Forms the 128-bit product from four 32 x 32 partial products, one per cycle,
// each registered, shifted to its weight and added into the accumulator.
// ============================================================================
module tt_mac (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [tt_pkg::OP_W-1:0]   op_a,
	input  logic [tt_pkg::OP_W-1:0]   op_b,
	output logic                      done,
	output logic [tt_pkg::PROD_W-1:0] prod
);
	import tt_pkg::*;

	localparam int HALF_W = OP_W / 2;

	logic [OP_W-1:0]   a_q;
	logic [OP_W-1:0]   b_q;
	logic              run_q;
	logic [1:0]        cnt_q;
	logic [OP_W-1:0]   pp_s1;
	logic [1:0]        sh_s1;
	logic              pv_s1;
	logic              last_s1;
	logic [PROD_W-1:0] acc_q;
	logic              done_q;

	logic [HALF_W-1:0] a_half;
	logic [HALF_W-1:0] b_half;
	logic [PROD_W-1:0] pp_shifted;

	// Select the operand halves for the current partial product.
	assign a_half = cnt_q[0] ? a_q[OP_W-1:HALF_W] : a_q[HALF_W-1:0];
	assign b_half = cnt_q[1] ? b_q[OP_W-1:HALF_W] : b_q[HALF_W-1:0];

	// Align the registered partial product to its weight.
	always_comb begin
		case (sh_s1)
			2'd0:    pp_shifted = {{OP_W{1'b0}}, pp_s1};
			2'd1:    pp_shifted = {{HALF_W{1'b0}}, pp_s1, {HALF_W{1'b0}}};
			2'd2:    pp_shifted = {pp_s1, {OP_W{1'b0}}};
			default: pp_shifted = '0;
		endcase
	end

	// Sequence the four partial products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			cnt_q   <= 2'd0;
			pv_s1   <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			pv_s1   <= run_q;
			last_s1 <= run_q && (cnt_q == 2'd3);
			done_q  <= pv_s1 && last_s1;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 2'd0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	// Operand capture, partial product register and accumulator.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= op_a;
			b_q   <= op_b;
			acc_q <= '0;
		end else if (pv_s1) begin
			acc_q <= acc_q + pp_shifted;
		end
		pp_s1 <= a_half * b_half;
		sh_s1 <= {1'b0, cnt_q[0]} + {1'b0, cnt_q[1]};
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

>>> rtl/tt_div.sv
// ============================================================================
// tt_div: bit-serial fixed-point divider for the final ratio
// Restoring division of the sinh sum by the cosh sum, one quotient bit per
// cycle, giving one integer bit and 30 fraction bits, or an overflow flag.
// ============================================================================
module tt_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [tt_pkg::MAG_W-1:0] num,
	input  logic [tt_pkg::MAG_W-1:0] den,
	output logic                     done,
	output logic                     ovf,
	output logic [tt_pkg::QUO_W-1:0] quot
);
	import tt_pkg::*;

	localparam int CNT_W = $clog2(QUO_W);

	logic [MAG_W:0]     rem_q;
	logic [MAG_W-1:0]   den_q;
	logic [QUO_W-1:0]   quo_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               run_q;
	logic               done_q;
	logic               ovf_q;

	logic               bit_d;
	logic [MAG_W:0]     diff;
	logic [MAG_W:0]     rem_next;

	// One restoring step: compare, subtract when it fits.
	assign diff     = rem_q - {1'b0, den_q};
	assign bit_d    = (rem_q >= {1'b0, den_q});
	assign rem_next = bit_d ? diff : rem_q;

	// Control: start, step count and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
			ovf_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				// A ratio of two or more cannot be represented.
				if ({1'b0, num} >= {den, 1'b0}) begin
					ovf_q  <= 1'b1;
					done_q <= 1'b1;
					run_q  <= 1'b0;
				end else begin
					ovf_q <= 1'b0;
					run_q <= 1'b1;
				end
			end else if (run_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(QUO_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			quo_q <= '0;
		end else if (run_q) begin
			rem_q <= {rem_next[MAG_W-1:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], bit_d};
		end
	end

	assign done = done_q;
	assign ovf  = ovf_q;
	assign quot = quo_q;

endmodule

>>> rtl/tt_checker.sv
// ============================================================================
// tt_checker: port-level checks of the tanh series core
// Watches the command and result handshakes of the top level over time.
// ============================================================================
module tt_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// An accepted transaction makes the core busy at once.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("core not busy after an accepted transaction");

	// A result closes a busy period and the core is free while it is shown.
	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(busy)))
		else $error("result strobe outside the end of a busy period");

	// The core only leaves busy by issuing a result.
	a_busy_falls_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	// The result strobe lasts a single cycle.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

endmodule

bind tanh_taylor_series_core tt_checker u_tt_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

>>> dv/tb_tanh_taylor_series_core.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_tanh_taylor_series_core: self-checking bench for the tanh series core
// A queue of pending operations (arguments, register writes and reads, and
// drain requests) feeds a clocked driver; a clocked monitor compares every
// result with a predictor that sums the sinh and cosh series in Q20.43 and
// forms the saturated Q1.30 ratio. Several term counts are exercised,
// including zero, the maximum and values beyond it.
// ============================================================================
module tb_tanh_taylor_series_core;

	localparam int MAX_TERMS    = 16;
	localparam int CLK_PERIOD   = 10;
	localparam int SETTLE_CYCLES = 800;
	localparam longint LIMIT_CYCLES = 10_000_000;
	localparam int MAX_PRINTS   = 100;

	localparam logic [tt_pkg::PADDR_W-1:0] ADDR_TERM_COUNT =
		tt_pkg::PADDR_W'(tt_pkg::REG_TERM_COUNT) << 2;
	localparam logic [tt_pkg::PADDR_W-1:0] ADDR_UNMAPPED = ADDR_TERM_COUNT + 3'd4;
	localparam logic [63:0] MAG_LIMIT = {1'b0, tt_pkg::MAG_MAX};

	typedef enum logic [1:0] {OP_ARG, OP_WRITE, OP_READ, OP_DRAIN} op_kind_t;
	typedef enum logic [2:0] {
		DRV_IDLE, DRV_CMD, DRV_QUIESCE, DRV_SETUP, DRV_ACCESS
	} drv_state_t;

	typedef struct {
		op_kind_t                    kind;
		logic [tt_pkg::PADDR_W-1:0]  addr;
		logic [31:0]                 data;
	} pending_op_t;

	typedef struct {
		logic [31:0] arg;
		logic [31:0] tanh_value;
		logic        saturated;
	} tanh_result_t;

	// DUT connections, all inputs known from time zero
	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        start   = 1'b0;
	logic [31:0] arg_x   = '0;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [tt_pkg::PADDR_W-1:0] paddr  = '0;
	logic [tt_pkg::PDATA_W-1:0] pwdata = '0;
	logic        busy;
	logic        done;
	logic signed [tt_pkg::RES_W-1:0] tanh_value;
	logic        saturated;
	logic [tt_pkg::PDATA_W-1:0] prdata;
	logic        pready;

	pending_op_t  pending_ops[$];
	tanh_result_t tanh_expected[$];
	pending_op_t  cur_op;
	tanh_result_t exp_res;
	drv_state_t   drv_state   = DRV_IDLE;
	logic [4:0]   term_count_model = tt_pkg::TERM_COUNT_RST;
	int           idle_left   = 0;
	int           next_gap    = 0;
	int           burst_left  = 0;
	int           issued_cnt  = 0;
	int           seen_cnt    = 0;
	int           err_cnt     = 0;
	longint       cycle_cnt   = 0;
	logic         stim_done   = 1'b0;

	tanh_taylor_series_core #(
		.MAX_TERMS (MAX_TERMS)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.arg_x      (arg_x),
		.done       (done),
		.tanh_value (tanh_value),
		.saturated  (saturated),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	// Free-running clock.
	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// One line per mismatch, with printing capped to keep the log short.
	task automatic report_mismatch(input string what);
		if (err_cnt < MAX_PRINTS)
			$display("%0t ns: mismatch: %s", $time, what);
		err_cnt++;
	endtask

	// Next series term: scale by x squared in Q20.43, then divide by the
	// two-factor denominator; an oversized product saturates the magnitude.
	function automatic logic [63:0] scale_term(input logic [63:0] term,
			input logic [63:0] x_sq, input logic [63:0] den, inout logic flag);
		logic [127:0] prod;
		logic [63:0]  t;
		prod = {64'd0, term} * {64'd0, x_sq};
		if (prod[127:106] != '0) begin
			t = MAG_LIMIT;
			flag = 1'b1;
		end else begin
			t = 64'(prod >> tt_pkg::FRAC_BITS);
		end
		return t / den;
	endfunction

	// Magnitude sum that clips at the largest Q20.43 value.
	function automatic logic [63:0] sum_clip(input logic [63:0] a, input logic [63:0] b,
			inout logic flag);
		if (b > MAG_LIMIT - a) begin
			flag = 1'b1;
			return MAG_LIMIT;
		end
		return a + b;
	endfunction

	// Expected tanh for one argument at the given term count.
	function automatic tanh_result_t tanh_series(input logic [31:0] x, input logic [4:0] tc);
		tanh_result_t r;
		logic         neg;
		logic         flag;
		logic [63:0]  xmag, x_sq, sinh_term, cosh_term, sinh_sum, cosh_sum;
		logic [63:0]  whole, q;
		logic [127:0] num;
		int           n;
		neg = x[31];
		xmag = {32'd0, neg ? (~x + 32'd1) : x};
		flag = 1'b0;
		x_sq = (xmag * xmag) >> 13;
		sinh_term = xmag << 15;
		cosh_term = 64'd1 << tt_pkg::FRAC_BITS;
		sinh_sum = sinh_term;
		cosh_sum = cosh_term;
		n = (tc == 0) ? 1 : ((int'(tc) > MAX_TERMS) ? MAX_TERMS : int'(tc));
		for (int i = 1; i < n; i++) begin
			sinh_term = scale_term(sinh_term, x_sq, 64'((2 * i) * (2 * i + 1)), flag);
			sinh_sum  = sum_clip(sinh_sum, sinh_term, flag);
			cosh_term = scale_term(cosh_term, x_sq, 64'((2 * i - 1) * (2 * i)), flag);
			cosh_sum  = sum_clip(cosh_sum, cosh_term, flag);
		end

		// Ratio with 30 fraction bits; an integer part of two or more is out of range.
		whole = sinh_sum / cosh_sum;
		if (whole >= 2) begin
			q = 64'h8000_0001;
		end else begin
			num = {64'd0, sinh_sum} << 30;
			q = 64'(num / {64'd0, cosh_sum});
		end

		// Apply the sign and clip to the 32-bit result range.
		if (neg) begin
			if (q > 64'h8000_0000) begin
				q = 64'h8000_0000;
				flag = 1'b1;
			end
			r.tanh_value = ~q[31:0] + 32'd1;
		end else begin
			if (q > 64'h7FFF_FFFF) begin
				q = 64'h7FFF_FFFF;
				flag = 1'b1;
			end
			r.tanh_value = q[31:0];
		end
		r.arg = x;
		r.saturated = flag;
		return r;
	endfunction

	// Idle length between operations: mostly short, a few long, with bursts of none.
	function automatic int pick_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			burst_left = $urandom_range(20, 60);
			return 0;
		end
		if (r < 40)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 30);
		return $urandom_range(40, 800);
	endfunction

	// Random argument, weighted towards the useful range but covering all bits.
	function automatic logic [31:0] random_arg();
		logic [31:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom();
			4, 5, 6: begin
				v = $urandom_range(0, 32'h1FFF_FFFF);
				return v - 32'h1000_0000;
			end
			7: begin
				v = $urandom_range(0, 255);
				return $urandom_range(0, 1) ? v : (~v + 32'd1);
			end
			8: begin
				v = $urandom_range(0, 15);
				return $urandom_range(0, 1) ? (32'h7FFF_FFFF - v) : (32'h8000_0000 + v);
			end
			default: begin
				v = $urandom_range(0, 15);
				return (v << 28) + $urandom_range(0, 2) - 32'd1;
			end
		endcase
	endfunction

	task automatic push_op(input op_kind_t kind, input logic [tt_pkg::PADDR_W-1:0] addr,
			input logic [31:0] data);
		pending_op_t op;
		op.kind = kind;
		op.addr = addr;
		op.data = data;
		pending_ops.push_back(op);
	endtask

	// A phase: set the term count (with random upper bits), read it back, then
	// random arguments with a full drain part-way through.
	task automatic add_phase(input logic [4:0] tc, input int count);
		logic [31:0] wdata;
		wdata = $urandom();
		wdata[4:0] = tc;
		push_op(OP_WRITE, ADDR_TERM_COUNT, wdata);
		push_op(OP_READ, ADDR_TERM_COUNT, '0);
		for (int i = 0; i < count; i++) begin
			if (i == count / 2)
				push_op(OP_DRAIN, '0, '0);
			push_op(OP_ARG, '0, random_arg());
		end
	endtask

	// Driver: pops pending operations, offers arguments on start and performs
	// register transactions only while the core is idle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start      <= 1'b0;
			psel       <= 1'b0;
			penable    <= 1'b0;
			pwrite     <= 1'b0;
			drv_state  <= DRV_IDLE;
			idle_left  <= 0;
			issued_cnt <= 0;
		end else begin
			case (drv_state)
				DRV_IDLE: begin
					if (idle_left != 0) begin
						idle_left <= idle_left - 1;
					end else if (pending_ops.size() != 0) begin
						cur_op = pending_ops.pop_front();
						if (cur_op.kind == OP_ARG) begin
							start     <= 1'b1;
							arg_x     <= cur_op.data;
							drv_state <= DRV_CMD;
						end else begin
							drv_state <= DRV_QUIESCE;
						end
					end else begin
						stim_done <= 1'b1;
					end
				end
				DRV_CMD: begin
					if (!busy) begin
						// Transaction taken at this edge
						tanh_expected.push_back(tanh_series(arg_x, term_count_model));
						issued_cnt <= issued_cnt + 1;
						next_gap = pick_gap();
						if (next_gap == 0 && pending_ops.size() != 0 &&
								pending_ops[0].kind == OP_ARG) begin
							cur_op = pending_ops.pop_front();
							arg_x <= cur_op.data;
						end else begin
							start     <= 1'b0;
							idle_left <= next_gap;
							drv_state <= DRV_IDLE;
						end
					end
				end
				DRV_QUIESCE: begin
					if (issued_cnt == seen_cnt && !busy) begin
						if (cur_op.kind == OP_DRAIN) begin
							idle_left <= pick_gap();
							drv_state <= DRV_IDLE;
						end else begin
							psel      <= 1'b1;
							pwrite    <= (cur_op.kind == OP_WRITE);
							paddr     <= cur_op.addr;
							pwdata    <= cur_op.data;
							drv_state <= DRV_SETUP;
						end
					end
				end
				DRV_SETUP: begin
					penable   <= 1'b1;
					drv_state <= DRV_ACCESS;
				end
				DRV_ACCESS: begin
					if (pready) begin
						if (pwrite) begin
							if (paddr[tt_pkg::PADDR_W-1:2] == tt_pkg::REG_TERM_COUNT)
								term_count_model = pwdata[4:0];
						end else if (prdata !== {27'd0, term_count_model}) begin
							report_mismatch($sformatf("term_count read %h, expected %h",
								prdata, term_count_model));
						end
						psel      <= 1'b0;
						penable   <= 1'b0;
						pwrite    <= 1'b0;
						idle_left <= pick_gap();
						drv_state <= DRV_IDLE;
					end
				end
				default: drv_state <= DRV_IDLE;
			endcase
		end
	end

	// Monitor: every strobed result is matched against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_cnt <= 0;
		end else if (done) begin
			seen_cnt <= seen_cnt + 1;
			if (tanh_expected.size() == 0) begin
				report_mismatch($sformatf("result with nothing outstanding: tanh_value=%h",
					tanh_value));
			end else begin
				exp_res = tanh_expected.pop_front();
				if (tanh_value !== exp_res.tanh_value)
					report_mismatch($sformatf("x=%h tanh_value %h, expected %h",
						exp_res.arg, tanh_value, exp_res.tanh_value));
				if (saturated !== exp_res.saturated)
					report_mismatch($sformatf("x=%h saturated %b, expected %b",
						exp_res.arg, saturated, exp_res.saturated));
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Stimulus plan, reset and end of run.
	initial begin
		logic [31:0] wdata;

		// Reset value read back, then edge arguments at the default term count
		push_op(OP_READ, ADDR_TERM_COUNT, '0);
		push_op(OP_ARG, '0, 32'h0000_0000);
		push_op(OP_ARG, '0, 32'h0000_0001);
		push_op(OP_ARG, '0, 32'hFFFF_FFFF);
		push_op(OP_ARG, '0, 32'h7FFF_FFFF);
		push_op(OP_ARG, '0, 32'h8000_0000);
		push_op(OP_ARG, '0, 32'h1000_0000);
		push_op(OP_ARG, '0, 32'hF000_0000);
		push_op(OP_ARG, '0, 32'h0800_0000);
		push_op(OP_ARG, '0, 32'h3000_0000);
		push_op(OP_ARG, '0, 32'h8800_0000);
		for (int i = 0; i < 200; i++) begin
			if (i == 100)
				push_op(OP_DRAIN, '0, '0);
			push_op(OP_ARG, '0, random_arg());
		end

		// A write outside the map must leave the term count alone
		push_op(OP_WRITE, ADDR_UNMAPPED, $urandom());
		push_op(OP_READ, ADDR_TERM_COUNT, '0);

		// Single term: the ratio is x itself, so results clip at a magnitude of two or more
		wdata = $urandom();
		wdata[4:0] = 5'd1;
		push_op(OP_WRITE, ADDR_TERM_COUNT, wdata);
		push_op(OP_ARG, '0, 32'h2000_0000);
		push_op(OP_ARG, '0, 32'hE000_0000);
		push_op(OP_ARG, '0, 32'h1FFF_FFFF);
		push_op(OP_ARG, '0, 32'hE000_0001);
		push_op(OP_ARG, '0, 32'h1000_0000);
		push_op(OP_ARG, '0, 32'hF000_0000);
		push_op(OP_ARG, '0, 32'h7FFF_FFFF);
		push_op(OP_ARG, '0, 32'h8000_0000);
		add_phase(5'd1, 150);

		// Full series length, the extremes first
		wdata = $urandom();
		wdata[4:0] = 5'd16;
		push_op(OP_WRITE, ADDR_TERM_COUNT, wdata);
		push_op(OP_ARG, '0, 32'h7FFF_FFFF);
		push_op(OP_ARG, '0, 32'h8000_0000);
		push_op(OP_ARG, '0, 32'h4000_0000);
		add_phase(5'd16, 150);

		// Zero terms act as one, counts past the maximum act as the maximum
		add_phase(5'd0, 80);
		add_phase(5'd31, 60);
		add_phase(5'd17, 40);

		for (int p = 0; p < 6; p++) begin
			if (p % 2 == 1)
				push_op(OP_WRITE, ADDR_UNMAPPED, $urandom());
			add_phase(5'($urandom_range(0, 31)), 110);
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		wait (stim_done);
		while (issued_cnt != seen_cnt)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (tanh_expected.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", tanh_expected.size()));

		if (err_cnt == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
